/* sv/rrfe_pkg.sv */
// Shared types, sizes and codes for the raster rectangle fill engine.
package rrfe_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int CRD_W = 7;
  localparam int CLR_W = 8;
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [CLR_W-1:0] BACKGROUND = 8'd79;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_DUMP  = 2'd2;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic KIND_PAINT = 1'b0;
  localparam logic KIND_DUMP  = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CRD_W-1:0] row_first;
    logic [CRD_W-1:0] row_last;
    logic [CRD_W-1:0] col_first;
    logic [CRD_W-1:0] col_last;
    logic [CLR_W-1:0] paint_color;
  } cmd_req_t;

  typedef struct packed {
    logic [CLR_W-1:0] pixel_value;
    logic [CRD_W-1:0] pixel_column;
    logic             row_end;
  } pix_data_t;

  // Classified work: 0-based inclusive box, already ordered and clipped.
  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row_lo;
    logic [ROW_W-1:0] row_hi;
    logic [COL_W-1:0] col_lo;
    logic [COL_W-1:0] col_hi;
    logic [CLR_W-1:0] color;
  } work_t;

endpackage

/* sv/rrfe_front.sv */
// Front end: size registers, request accept, ordering and clipping into work.
module rrfe_front
  import rrfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic [CRD_W-1:0] cfg_data,
  input  logic             cmd_valid,
  input  cmd_req_t         cmd_req,
  output logic             cmd_stall,
  input  logic             q_full,
  input  logic             init_busy,
  output logic             push,
  output work_t            work
);

  logic [CRD_W-1:0] image_width;
  logic [CRD_W-1:0] image_height;
  logic [CRD_W-1:0] w_used;
  logic [CRD_W-1:0] h_used;
  logic             is_clear;
  logic [CRD_W-1:0] ra, rb, ca, cb;
  logic [CRD_W-1:0] r_lo, r_hi, c_lo, c_hi;
  logic             box_empty;
  logic             dump_ok;
  logic             has_work;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CRD_W'(64);
      image_height <= CRD_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_used = (32'(image_width) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : image_width;
    h_used = (32'(image_height) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : image_height;

    is_clear = (cmd_req.mode == MODE_CLEAR);
    ra = is_clear ? CRD_W'(1) : cmd_req.row_first;
    rb = is_clear ? h_used    : cmd_req.row_last;
    ca = is_clear ? CRD_W'(1) : cmd_req.col_first;
    cb = is_clear ? w_used    : cmd_req.col_last;

    r_lo = (ra < rb) ? ra : rb;
    r_hi = (ra < rb) ? rb : ra;
    c_lo = (ca < cb) ? ca : cb;
    c_hi = (ca < cb) ? cb : ca;
    if (r_lo == '0) r_lo = CRD_W'(1);
    if (c_lo == '0) c_lo = CRD_W'(1);
    if (r_hi > h_used) r_hi = h_used;
    if (c_hi > w_used) c_hi = w_used;
    box_empty = (r_lo > r_hi) || (c_lo > c_hi);

    dump_ok = (cmd_req.row_first != '0) && (cmd_req.row_first <= h_used) &&
              (w_used != '0);

    work = '0;
    has_work = 1'b0;
    unique case (cmd_req.mode) inside
      MODE_CLEAR, MODE_FILL: begin
        has_work    = !box_empty;
        work.kind   = KIND_PAINT;
        work.row_lo = ROW_W'(r_lo - CRD_W'(1));
        work.row_hi = ROW_W'(r_hi - CRD_W'(1));
        work.col_lo = COL_W'(c_lo - CRD_W'(1));
        work.col_hi = COL_W'(c_hi - CRD_W'(1));
        work.color  = is_clear ? BACKGROUND : cmd_req.paint_color;
      end
      MODE_DUMP: begin
        has_work    = dump_ok;
        work.kind   = KIND_DUMP;
        work.row_lo = ROW_W'(cmd_req.row_first - CRD_W'(1));
        work.row_hi = ROW_W'(cmd_req.row_first - CRD_W'(1));
        work.col_lo = '0;
        work.col_hi = COL_W'(w_used - CRD_W'(1));
      end
      default: has_work = 1'b0;
    endcase
  end

  assign cmd_stall = q_full || init_busy;
  assign push      = cmd_valid && !cmd_stall && has_work;

endmodule

/* sv/rrfe_cmd_queue.sv */
// Short work queue between front end and back end.
module rrfe_cmd_queue
  import rrfe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_work,
  input  logic  pop,
  output logic  q_valid,
  output logic  q_full,
  output work_t head
);

  work_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (32'(count) == QDEPTH);
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

/* sv/rrfe_back.sv */
// Back end: pixel store, box painter, row dump and power-up clearing pass.
module rrfe_back
  import rrfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  work_t     head,
  output logic      pop,
  output logic      init_busy,
  output logic      pix_valid,
  input  logic      pix_stall,
  output pix_data_t pix_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PAINT = 2'd1;
  localparam logic [1:0] ST_DUMP  = 2'd2;

  logic [CLR_W-1:0] mem [MEM_DEPTH];
  logic [1:0]       state;
  work_t            cur;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;
  logic             last_col;
  logic             last_row;
  logic [ADDR_W-1:0] addr;
  logic             we;
  logic             rd_en;
  logic [CLR_W-1:0] rd_data;
  logic [CRD_W-1:0] col_out;
  logic             end_out;

  assign last_col = (c == cur.col_hi);
  assign last_row = (r == cur.row_hi);
  assign addr     = ADDR_W'(int'(r) * MAX_WIDTH + int'(c));
  assign we       = (state == ST_PAINT);
  assign rd_en    = (state == ST_DUMP) && (!pix_valid || !pix_stall);
  assign pop      = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= cur.color;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      col_out <= CRD_W'(c) + CRD_W'(1);
      end_out <= last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_PAINT;
      init_busy   <= 1'b1;
      cur.kind    <= KIND_PAINT;
      cur.row_lo  <= '0;
      cur.row_hi  <= ROW_W'(MAX_HEIGHT - 1);
      cur.col_lo  <= '0;
      cur.col_hi  <= COL_W'(MAX_WIDTH - 1);
      cur.color   <= BACKGROUND;
      r           <= '0;
      c           <= '0;
      pix_valid   <= 1'b0;
    end else begin
      if (rd_en) pix_valid <= 1'b1;
      else if (!pix_stall) pix_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= head;
            r     <= head.row_lo;
            c     <= head.col_lo;
            state <= (head.kind == KIND_DUMP) ? ST_DUMP : ST_PAINT;
          end
        end
        ST_PAINT: begin
          if (last_col) begin
            c <= cur.col_lo;
            r <= r + ROW_W'(1);
            if (last_row) begin
              state     <= ST_IDLE;
              init_busy <= 1'b0;
            end
          end else begin
            c <= c + COL_W'(1);
          end
        end
        ST_DUMP: begin
          if (rd_en) begin
            if (last_col) state <= ST_IDLE;
            else c <= c + COL_W'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pix_data.pixel_value  = rd_data;
  assign pix_data.pixel_column = col_out;
  assign pix_data.row_end      = end_out;

  a_init_paints: assert property (@(posedge clk) disable iff (rst)
      init_busy |-> (state == ST_PAINT))
    else $error("clearing pass left paint state");
  a_col_in_box: assert property (@(posedge clk) disable iff (rst)
      (state == ST_PAINT || state == ST_DUMP) |-> (c >= cur.col_lo && c <= cur.col_hi))
    else $error("column outside box");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
      init_busy |-> !pop)
    else $error("work taken during clearing pass");

endmodule

/* sv/raster_rectangle_fill_engine.sv */
// Top level of the raster rectangle fill engine.
// After reset a clearing pass paints all MAX_WIDTH*MAX_HEIGHT (4096) pixels of the store
// with 79; requests are stalled until it ends, configuration writes are taken at once.
// A fill or clear paints its box row by row from its top-left corner; a dump reads the
// row from its first column to its last and flags the last pixel with row_end.
// The single store write/read port sets the rate: one pixel per cycle when not stalled.
// Reset restores both size registers to 64; a 4-entry queue decouples requests.
module raster_rectangle_fill_engine
  import rrfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CRD_W-1:0] cfg_data,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  cmd_req_t         cmd_req,
  output logic             pix_valid,
  input  logic             pix_stall,
  output pix_data_t        pix_data
);

  logic  push;
  work_t push_work;
  logic  pop;
  logic  q_valid;
  logic  q_full;
  work_t head;
  logic  init_busy;

  assign cfg_ready = 1'b1;

  rrfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_req   (cmd_req),
    .cmd_stall (cmd_stall),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .work      (push_work)
  );

  rrfe_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_work (push_work),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head)
  );

  rrfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .init_busy (init_busy),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data)
  );

endmodule

/* sim/tb_top.sv */
// Testbench for the raster rectangle fill engine: directed and random commands checked against a pixel-store predictor.
`timescale 1ns / 100ps

module tb_top;
  import rrfe_pkg::*;

  localparam int SETTLE_CYCLES = 5 * (MAX_WIDTH * MAX_HEIGHT + 4);
  localparam int PHASE_ITEMS   = 55;
  localparam int MAX_REPORTS   = 40;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum {STALL_NONE, STALL_HALF, STALL_PERIODIC, STALL_SPARSE} stall_style_e;

  class raster_scoreboard;
    logic [CLR_W-1:0] canvas [MAX_HEIGHT][MAX_WIDTH];
    int unsigned width_reg;
    int unsigned height_reg;
    pix_data_t expected_pixels[$];
    int errors;

    function new();
      foreach (canvas[r, c]) canvas[r][c] = BACKGROUND;
      width_reg = 64;
      height_reg = 64;
      errors = 0;
    endfunction

    function int unsigned used_cols();
      return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function int unsigned used_rows();
      return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void set_size(logic idx, logic [CRD_W-1:0] value);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = value;
      end else begin
        height_reg = value;
      end
    endfunction

    // Inclusive 1-based box, ends in either order, clipped to the area in use.
    function void paint(int unsigned r0, int unsigned r1, int unsigned c0, int unsigned c1,
                        logic [CLR_W-1:0] color);
      int unsigned t;
      int unsigned h;
      int unsigned w;
      h = used_rows();
      w = used_cols();
      if (r0 > r1) begin
        t = r0; r0 = r1; r1 = t;
      end
      if (c0 > c1) begin
        t = c0; c0 = c1; c1 = t;
      end
      if (r0 < 1) r0 = 1;
      if (c0 < 1) c0 = 1;
      if (r1 > h) r1 = h;
      if (c1 > w) c1 = w;
      if (r0 > r1 || c0 > c1) return;
      for (int unsigned r = r0; r <= r1; r++)
        for (int unsigned c = c0; c <= c1; c++)
          canvas[r-1][c-1] = color;
    endfunction

    function void note_cmd(cmd_req_t req);
      int unsigned w;
      pix_data_t pix;
      w = used_cols();
      case (req.mode)
        MODE_CLEAR: paint(1, used_rows(), 1, w, BACKGROUND);
        MODE_FILL: paint(req.row_first, req.row_last, req.col_first, req.col_last,
                         req.paint_color);
        MODE_DUMP: begin
          if (req.row_first >= 1 && req.row_first <= used_rows()) begin
            for (int unsigned c = 0; c < w; c++) begin
              pix.pixel_value  = canvas[req.row_first-1][c];
              pix.pixel_column = CRD_W'(c + 1);
              pix.row_end      = (c + 1 == w);
              expected_pixels.push_back(pix);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_pixel(pix_data_t got);
      pix_data_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("unexpected pixel %p", got));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_value !== want.pixel_value)
        report($sformatf("pixel_value %0d, expected %0d (column %0d)",
                         got.pixel_value, want.pixel_value, want.pixel_column));
      if (got.pixel_column !== want.pixel_column)
        report($sformatf("pixel_column %0d, expected %0d", got.pixel_column, want.pixel_column));
      if (got.row_end !== want.row_end)
        report($sformatf("row_end %0b, expected %0b (column %0d)",
                         got.row_end, want.row_end, want.pixel_column));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = REG_IMAGE_WIDTH;
  logic [CRD_W-1:0] cfg_data = '0;
  logic             cmd_valid = 1'b0;
  logic             cmd_stall;
  cmd_req_t         cmd_req = '0;
  logic             pix_valid;
  logic             pix_stall = 1'b0;
  pix_data_t        pix_data;

  raster_scoreboard sb = new();
  int               burst_left = 0;
  int unsigned      stall_tick = 0;
  stall_style_e     stall_style = STALL_NONE;

  raster_rectangle_fill_engine DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_req(cmd_req),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix_data(pix_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (stall_tick % 300 == 0) stall_style = stall_style_e'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:     pix_stall <= 1'b0;
      STALL_HALF:     pix_stall <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: pix_stall <= (stall_tick % 5 < 3);
      default:        pix_stall <= ($urandom_range(0, 4) == 0);
    endcase
    stall_tick++;
  end

  always @(posedge clk) begin
    if (!rst && pix_valid === 1'b1 && !pix_stall) sb.check_pixel(pix_data);
  end

  function automatic cmd_req_t mk_cmd(logic [1:0] mode, int rf, int rl, int cf, int cl,
                                      int color);
    cmd_req_t req;
    req.mode        = mode;
    req.row_first   = CRD_W'(rf);
    req.row_last    = CRD_W'(rl);
    req.col_first   = CRD_W'(cf);
    req.col_last    = CRD_W'(cl);
    req.paint_color = CLR_W'(color);
    return req;
  endfunction

  // Mostly small boxes and dumps inside the area; some fully random coordinates.
  function automatic cmd_req_t random_cmd();
    cmd_req_t req;
    int unsigned pick;
    int unsigned rows;
    int unsigned cols;
    rows = (sb.used_rows() > 0) ? sb.used_rows() : 1;
    cols = (sb.used_cols() > 0) ? sb.used_cols() : 1;
    req = mk_cmd(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      req.mode = MODE_CLEAR;
    end else if (pick < 8) begin
      req.mode = MODE_UNUSED;
    end else if (pick < 52) begin
      req.mode = MODE_FILL;
      if (pick < 45) begin
        req.row_first = CRD_W'($urandom_range(1, rows));
        req.row_last  = req.row_first + CRD_W'($urandom_range(0, 7));
        req.col_first = CRD_W'($urandom_range(1, cols));
        req.col_last  = req.col_first + CRD_W'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) {req.row_first, req.row_last} = {req.row_last, req.row_first};
        if ($urandom_range(0, 1) == 1) {req.col_first, req.col_last} = {req.col_last, req.col_first};
      end
    end else begin
      req.mode = MODE_DUMP;
      if (pick < 95) req.row_first = CRD_W'($urandom_range(1, rows));
    end
    return req;
  endfunction

  task automatic send_cmd(input cmd_req_t req);
    cmd_valid <= 1'b1;
    cmd_req <= req;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    sb.note_cmd(req);
    if (burst_left == 0) begin
      cmd_valid <= 1'b0;
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_size(input int unsigned cols, input int unsigned rows);
    cfg_valid <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= CRD_W'(cols);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_size(REG_IMAGE_WIDTH, CRD_W'(cols));
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data <= CRD_W'(rows);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_size(REG_IMAGE_HEIGHT, CRD_W'(rows));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait out every expected pixel, then long enough for queued paints to finish.
  task automatic drain();
    cmd_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_cols[8];
    int unsigned phase_rows[8];
    int done;
    cmd_req_t req;
    phase_cols = '{1, 127, 0, 12, 65, 0, 37, 64};
    phase_rows = '{1, 100, 9, 0, 3, 0, 64, 64};
    phase_cols[5] = $urandom_range(1, 64);
    phase_rows[5] = $urandom_range(1, 64);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_size(64, 64);

    send_cmd(mk_cmd(MODE_DUMP, 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_FILL, 64, 1, 64, 1, 255));
    send_cmd(mk_cmd(MODE_DUMP, 64, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_FILL, 1, 1, 1, 1, 0));
    send_cmd(mk_cmd(MODE_FILL, 2, 2, 64, 1, 8'h5a));
    send_cmd(mk_cmd(MODE_FILL, 1, 64, 64, 64, 8'ha5));
    send_cmd(mk_cmd(MODE_FILL, 0, 3, 3, 0, 17));
    send_cmd(mk_cmd(MODE_FILL, 127, 60, 62, 127, 200));
    send_cmd(mk_cmd(MODE_FILL, 100, 127, 1, 64, 1));
    send_cmd(mk_cmd(MODE_FILL, 0, 0, 1, 64, 2));
    send_cmd(mk_cmd(MODE_UNUSED, 127, 127, 127, 127, 255));
    send_cmd(mk_cmd(MODE_DUMP, 0, 5, 5, 5, 5));
    send_cmd(mk_cmd(MODE_DUMP, 127, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 2, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 3, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 60, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 64, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 1, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_DUMP, 64, 0, 0, 0, 0));
    send_cmd(mk_cmd(MODE_FILL, 1, 64, 1, 64, 8'h33));
    send_cmd(mk_cmd(MODE_DUMP, 32, 0, 0, 0, 0));

    foreach (phase_cols[p]) begin
      drain();
      write_size(phase_cols[p], phase_rows[p]);
      done = 0;
      while (done < PHASE_ITEMS) begin
        req = random_cmd();
        send_cmd(req);
        if (req.mode != MODE_UNUSED) done++;
      end
    end
    drain();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(80_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
